// ===== rtl/dpph_pkg.sv =====
// Shared types, codes and helper functions of the dotted-pair parser.
package dpph_pkg;

  localparam logic [3:0] ERR_NONE     = 4'd0;
  localparam logic [3:0] ERR_DISABLED = 4'd1;
  localparam logic [3:0] ERR_OPEN     = 4'd2;
  localparam logic [3:0] ERR_ATOM     = 4'd3;
  localparam logic [3:0] ERR_LONG     = 4'd4;
  localparam logic [3:0] ERR_DOT      = 4'd5;
  localparam logic [3:0] ERR_CLOSE    = 4'd6;
  localparam logic [3:0] ERR_TRAIL    = 4'd7;
  localparam logic [3:0] ERR_DEEP     = 4'd8;

  localparam logic [1:0] PH_CAR   = 2'd0;
  localparam logic [1:0] PH_DOT   = 2'd1;
  localparam logic [1:0] PH_CDR   = 2'd2;
  localparam logic [1:0] PH_CLOSE = 2'd3;

  localparam logic [1:0] OS_AWAIT  = 2'd0;
  localparam logic [1:0] OS_INSIDE = 2'd1;
  localparam logic [1:0] OS_DONE   = 2'd2;

  localparam logic [2:0] NF_START = 3'd0;
  localparam logic [2:0] NF_SIGN  = 3'd1;
  localparam logic [2:0] NF_ZERO  = 3'd2;
  localparam logic [2:0] NF_X     = 3'd3;
  localparam logic [2:0] NF_HEX   = 3'd4;
  localparam logic [2:0] NF_OCT   = 3'd5;
  localparam logic [2:0] NF_DEC   = 3'd6;
  localparam logic [2:0] NF_BAD   = 3'd7;

  localparam logic [2:0] NM_DONE = 3'd4;
  localparam logic [2:0] NM_FAIL = 3'd5;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [4:0] DIGIT_NONE = 5'd16;

  localparam int QDEPTH = 4;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;

  // One classified input byte.
  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
    logic       nul;
    logic       space;
    logic       sep;
    logic [4:0] digit;
  } word_t;

  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] d;
    d = DIGIT_NONE;
    if (c >= 8'h30 && c <= 8'h39) d = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) d = 5'(c - 8'h61 + 8'd10);
    else if (c >= 8'h41 && c <= 8'h46) d = 5'(c - 8'h41 + 8'd10);
    return d;
  endfunction

  function automatic logic [7:0] null_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h4e;
      2'd1:    c = 8'h55;
      default: c = 8'h4c;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/dpph_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dpph_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dpph_front.sv =====
// Front end: classify incoming bytes and hold them in a short word queue.
module dpph_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  logic [7:0]      text_byte_i,
  input  logic            end_of_text_i,
  output logic            valid_o,
  output dpph_pkg::word_t word_o,
  input  logic            take_i
);
  import dpph_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  word_t           store_q [QDEPTH];
  word_t           cls;
  logic [PW-1:0]   wptr_q, rptr_q;
  logic [PW:0]     cnt_q, cnt_d;
  logic            wr, rd;

  always_comb begin
    cls.ch    = text_byte_i;
    cls.eot   = end_of_text_i;
    cls.nul   = (text_byte_i == 8'h00);
    cls.space = (text_byte_i == 8'h20) || (text_byte_i inside {[8'h09:8'h0d]});
    cls.sep   = cls.space || text_byte_i == CH_OPEN || text_byte_i == CH_CLOSE ||
                text_byte_i == CH_DOT;
    cls.digit = digit_of(text_byte_i);
  end

  assign full    = (cnt_q == (PW+1)'(QDEPTH));
  assign wr      = push && !full;
  assign valid_o = (cnt_q != '0);
  assign rd      = take_i && valid_o;
  assign word_o  = store_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr && !rd) cnt_d = cnt_q + 1'b1;
    else if (rd && !wr) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      store_q[wptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr) wptr_q <= wptr_q + 1'b1;
      if (rd) rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/dpph_back.sv =====
// Back end: parse a classified word per cycle, end markers may stall; register result.
module dpph_back #(
  parameter int MAX_TOKEN   = 32,
  parameter int MAX_NESTING = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            dot_enabled_i,
  input  logic            valid_i,
  input  dpph_pkg::word_t word_i,
  output logic            take_o,
  output logic            empty,
  input  logic            pop,
  output logic            accepted_o,
  output logic [3:0]      error_code_o,
  output logic [15:0]     witness_o
);
  import dpph_pkg::*;

  localparam int DW = $clog2(MAX_NESTING + 1);
  localparam int AW = $clog2(MAX_NESTING);
  localparam int TW = $clog2(MAX_TOKEN + 1);

  logic [DW-1:0] depth_q, depth_d;
  logic [1:0]    outer_q, outer_d;
  logic [1:0]    top_q, top_d;
  logic [TW-1:0] tlen_q, tlen_d;
  logic [31:0]   hash_q, hash_d;
  logic [16:0]   nval_q, nval_d;
  logic [3:0]    nform_q, nform_d;
  logic [2:0]    nmat_q, nmat_d;
  logic [15:0]   acc_q, acc_d;
  logic [3:0]    err_q, err_d;
  logic          byp_q, byp_d;
  logic [1:0]    bypd_q;
  logic          out_valid_q, out_valid_d;
  logic [3:0]    res_err_q, res_err_d;
  logic [15:0]   res_wit_q, res_wit_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [1:0]    ram_rdata, below;

  logic          out_space, take;
  logic [2:0]    f;
  logic          neg, numeric;
  logic [15:0]   code;
  logic [1:0]    ph;
  logic          tok_act;
  logic [TW-1:0] tl_b;
  logic [31:0]   h_b;
  logic [16:0]   nv_b;
  logic [3:0]    nf_b;
  logic [2:0]    nm_b;
  logic [2:0]    nf_f;
  logic          nf_neg;
  logic [2:0]    nf_n;
  logic [21:0]   mac;
  logic [4:0]    dg;
  logic [7:0]    c;
  logic          do_tok;

  dpph_ram #(.WIDTH(2), .DEPTH(MAX_NESTING)) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ph),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Phase of the pair just below the top; the written value wins on a same-address hit.
  assign below     = byp_q ? bypd_q : ram_rdata;
  assign out_space = !out_valid_q || pop;
  assign take      = valid_i && (!word_i.eot || out_space);
  assign take_o    = take;
  assign c         = word_i.ch;
  assign dg        = word_i.digit;

  // Atom code of the token currently held.
  always_comb begin
    f       = nform_q[2:0];
    neg     = nform_q[3];
    numeric = (f == NF_ZERO || f == NF_HEX || f == NF_OCT || f == NF_DEC) &&
              !nval_q[16] && (!neg || nval_q == '0);
    if (tlen_q == TW'(4) && nmat_q == NM_DONE) code = '0;
    else if (numeric) code = nval_q[15:0];
    else code = hash_q[31:16] ^ hash_q[15:0];
  end

  always_comb begin
    depth_d     = depth_q;
    outer_d     = outer_q;
    top_d       = top_q;
    tlen_d      = tlen_q;
    hash_d      = hash_q;
    nval_d      = nval_q;
    nform_d     = nform_q;
    nmat_d      = nmat_q;
    acc_d       = acc_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && !pop;
    res_err_d   = res_err_q;
    res_wit_d   = res_wit_q;
    ram_we      = 1'b0;
    ram_waddr   = AW'(depth_q - 1'b1);
    tok_act     = (err_q == ERR_NONE) && (tlen_q != '0);
    ph          = tok_act ? top_q + 1'b1 : top_q;
    tl_b        = '0;
    h_b         = FNV_BASIS;
    nv_b        = '0;
    nf_b        = {1'b0, NF_START};
    nm_b        = '0;
    do_tok      = 1'b0;
    nf_f        = NF_BAD;
    nf_neg      = 1'b0;
    nf_n        = NF_BAD;
    mac         = '0;

    if (take && word_i.eot) begin
      // Close a pending token, pick the first missing construct, then clear the parse.
      out_valid_d = 1'b1;
      if (!dot_enabled_i) res_err_d = ERR_DISABLED;
      else if (err_q != ERR_NONE) res_err_d = err_q;
      else if (outer_q == OS_AWAIT) res_err_d = ERR_OPEN;
      else if (outer_q == OS_DONE) res_err_d = ERR_NONE;
      else if (ph == PH_CAR || ph == PH_CDR) res_err_d = ERR_ATOM;
      else if (ph == PH_DOT) res_err_d = ERR_DOT;
      else res_err_d = ERR_CLOSE;
      res_wit_d = (res_err_d == ERR_NONE) ? (tok_act ? acc_q ^ code : acc_q) : '0;
      depth_d   = '0;
      outer_d   = OS_AWAIT;
      acc_d     = '0;
      err_d     = ERR_NONE;
      tlen_d    = '0;
      hash_d    = FNV_BASIS;
      nval_d    = '0;
      nform_d   = {1'b0, NF_START};
      nmat_d    = '0;
    end else if (take && err_q == ERR_NONE && !word_i.nul) begin
      if (tlen_q != '0 && !word_i.sep) begin
        tl_b   = tlen_q;
        h_b    = hash_q;
        nv_b   = nval_q;
        nf_b   = nform_q;
        nm_b   = nmat_q;
        do_tok = 1'b1;
      end else begin
        if (tok_act) begin
          acc_d   = acc_q ^ code;
          tlen_d  = '0;
          hash_d  = FNV_BASIS;
          nval_d  = '0;
          nform_d = {1'b0, NF_START};
          nmat_d  = '0;
          top_d   = ph;
        end
        if (!word_i.space) begin
          if (outer_q == OS_AWAIT) begin
            if (c == CH_OPEN) begin
              depth_d = DW'(1);
              top_d   = PH_CAR;
              outer_d = OS_INSIDE;
            end else begin
              err_d = ERR_OPEN;
            end
          end else if (outer_q != OS_INSIDE) begin
            err_d = ERR_TRAIL;
          end else if (ph == PH_CAR || ph == PH_CDR) begin
            if (c == CH_OPEN) begin
              if (depth_q >= DW'(MAX_NESTING)) begin
                err_d = ERR_DEEP;
              end else begin
                ram_we  = 1'b1;
                depth_d = depth_q + 1'b1;
                top_d   = PH_CAR;
              end
            end else if (c == CH_CLOSE || c == CH_DOT) begin
              err_d = ERR_ATOM;
            end else begin
              do_tok = 1'b1;
            end
          end else if (ph == PH_DOT) begin
            if (c == CH_DOT) top_d = PH_CDR;
            else err_d = ERR_DOT;
          end else begin
            if (c != CH_CLOSE) begin
              err_d = ERR_CLOSE;
            end else begin
              depth_d = depth_q - 1'b1;
              if (depth_q == DW'(1)) outer_d = OS_DONE;
              else top_d = below + 1'b1;
            end
          end
        end
      end
    end

    if (do_tok) begin
      // Hash, NULL match and number recognizer advance on one token byte.
      hash_d = (h_b ^ {24'd0, c}) * FNV_PRIME;
      if (nm_b < NM_DONE && c == null_char(nm_b[1:0])) nmat_d = nm_b + 1'b1;
      else nmat_d = NM_FAIL;
      nf_f   = nf_b[2:0];
      nf_neg = nf_b[3];
      nf_n   = NF_BAD;
      nval_d = nv_b;
      case (nf_f)
        NF_START, NF_SIGN: begin
          if (nf_f == NF_START && c == CH_PLUS) begin
            nf_n = NF_SIGN;
          end else if (nf_f == NF_START && c == CH_MINUS) begin
            nf_n   = NF_SIGN;
            nf_neg = 1'b1;
          end else if (c == CH_ZERO) begin
            nf_n = NF_ZERO;
          end else if (dg >= 5'd1 && dg <= 5'd9) begin
            nf_n   = NF_DEC;
            nval_d = 17'(dg);
          end
        end
        NF_ZERO: begin
          if (c == CH_X_LO || c == CH_X_UP) begin
            nf_n = NF_X;
          end else if (dg <= 5'd7) begin
            nf_n   = NF_OCT;
            nval_d = 17'(dg);
          end
        end
        NF_X: begin
          if (dg < 5'd16) begin
            nf_n   = NF_HEX;
            nval_d = 17'(dg);
          end
        end
        NF_HEX: begin
          if (dg < 5'd16) begin
            nf_n = NF_HEX;
            mac  = {1'b0, nv_b, 4'd0} + 22'(dg);
          end
        end
        NF_OCT: begin
          if (dg <= 5'd7) begin
            nf_n = NF_OCT;
            mac  = {2'd0, nv_b, 3'd0} + 22'(dg);
          end
        end
        NF_DEC: begin
          if (dg <= 5'd9) begin
            nf_n = NF_DEC;
            mac  = {2'd0, nv_b, 3'd0} + {4'd0, nv_b, 1'b0} + 22'(dg);
          end
        end
        default: nf_n = NF_BAD;
      endcase
      if (nf_f == NF_HEX || nf_f == NF_OCT || nf_f == NF_DEC) begin
        if (nf_n != NF_BAD) nval_d = (mac > 22'hffff) ? 17'h10000 : mac[16:0];
      end
      nform_d = {nf_neg, nf_n};
      tlen_d  = tl_b + 1'b1;
      if (tlen_d >= TW'(MAX_TOKEN)) err_d = ERR_LONG;
    end
  end

  // Prefetch the entry under the next top so a close finds it ready.
  assign ram_raddr = AW'(depth_d - DW'(2));
  assign byp_d     = ram_we;

  always_ff @(posedge clk_i) begin
    bypd_q    <= ph;
    hash_q    <= hash_d;
    nval_q    <= nval_d;
    res_err_q <= res_err_d;
    res_wit_q <= res_wit_d;
    top_q     <= top_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      outer_q     <= OS_AWAIT;
      tlen_q      <= '0;
      nform_q     <= {1'b0, NF_START};
      nmat_q      <= '0;
      acc_q       <= '0;
      err_q       <= ERR_NONE;
      byp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      depth_q     <= depth_d;
      outer_q     <= outer_d;
      tlen_q      <= tlen_d;
      nform_q     <= nform_d;
      nmat_q      <= nmat_d;
      acc_q       <= acc_d;
      err_q       <= err_d;
      byp_q       <= byp_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign empty        = !out_valid_q;
  assign accepted_o   = (res_err_q == ERR_NONE);
  assign error_code_o = res_err_q;
  assign witness_o    = res_wit_q;

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(MAX_NESTING)) else $error("nesting depth beyond limit");
  a_err_wit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_err_q != ERR_NONE |-> res_wit_q == '0)
    else $error("nonzero witness on error");
  a_outer_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (outer_q == OS_AWAIT || outer_q == OS_DONE) |-> depth_q == '0)
    else $error("open pairs outside a declaration");
  a_new_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(take && word_i.eot))
    else $error("result without end marker");
`endif

endmodule

// ===== rtl/dotted_pair_parse_and_hash_top.sv =====
// Top level of the dotted-pair declaration parser with 16-bit atom witness.
//
// Usage: text enters one byte per word on the push/full queue port with
// end_of_text_i low; a word with end_of_text_i high closes the declaration
// and yields exactly one result word (accepted, error code, witness) on the
// empty/pop queue port. Byte words give no result.
// Throughput: one word per cycle sustained while results are popped; the
// front queue takes a word while the parser works on an earlier one, and
// the parser retires one queued word per cycle unless an end marker stalls.
// Result path: an end marker pushed into an empty queue passes the queue
// register and then the result register on its way to the result ports.
// Stall: when the result is not popped, the parser takes byte words up to
// the next end marker and holds that marker with all words behind it; the
// 4-word front queue then fills and raises full.
// Reset: the queues empty, the parse starts awaiting "(", and dot_enabled
// clears. The nesting stack memory needs no clearing pass: an entry is
// only read after it was pushed.
// Configuration: write dot_enabled with cfg_we_i only while idle.
module dotted_pair_parse_and_hash_top #(
  parameter int MAX_TOKEN   = 32,
  parameter int MAX_NESTING = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  output logic        empty,
  input  logic        pop,
  output logic        accepted_o,
  output logic [3:0]  error_code_o,
  output logic [15:0] witness_o
);
  import dpph_pkg::*;

  logic  dot_q;
  logic  wvalid, wtake;
  word_t word;

  // Hold the mode bit; the parser samples it at each end marker.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= 1'b0;
    end else if (cfg_we_i) begin
      dot_q <= cfg_wdata_i;
    end
  end

  // Classify each byte and queue it for the parser.
  dpph_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .valid_o       (wvalid),
    .word_o        (word),
    .take_i        (wtake)
  );

  // Advance the parse one word per cycle while results are popped, and register results.
  dpph_back #(
    .MAX_TOKEN   (MAX_TOKEN),
    .MAX_NESTING (MAX_NESTING)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dot_enabled_i (dot_q),
    .valid_i       (wvalid),
    .word_i        (word),
    .take_o        (wtake),
    .empty         (empty),
    .pop           (pop),
    .accepted_o    (accepted_o),
    .error_code_o  (error_code_o),
    .witness_o     (witness_o)
  );

endmodule
